>>> hdl/wis_pkg.sv
`default_nettype none

package wis_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DRAW_W   = 26;
  localparam int unsigned TOTAL_W  = 26;
  localparam int unsigned NODE_W   = 10;

  typedef logic [TOTAL_W-1:0] total_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/wis_table.sv
`default_nettype none

// single-port prefix table, registered read
module wis_table #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 26
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // unused candidates may fall past DEPTH; the compare drops that data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> hdl/wis_cell.sv
`default_nettype none

// one search cell: decides bit BIT of the answer in two phases
// (address out, then compare), hands the partial index on
module wis_cell import wis_pkg::*; #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned BIT   = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tok_valid_i,
  input  wire logic [IDX_W-1:0] tok_found_i,
  input  wire logic [CNT_W-1:0] node_count_i,
  input  wire total_t           draw_i,
  input  wire total_t           rd_data_i,
  output logic                  rd_req_o,
  output logic      [IDX_W-1:0] rd_addr_o,
  output logic                  tok_valid_o,
  output logic      [IDX_W-1:0] tok_found_o
);

  logic             addr_ph_q;
  logic             cmp_ph_q;
  logic [IDX_W-1:0] found_q;
  logic [IDX_W-1:0] found_d;
  logic [IDX_W-1:0] cand;
  logic             take;

  assign cand = found_q | (IDX_W'(1) << BIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_ph_q <= 1'b0;
      cmp_ph_q  <= 1'b0;
    end else begin
      addr_ph_q <= tok_valid_i;
      cmp_ph_q  <= addr_ph_q;
    end
  end

  assign found_d = tok_valid_i ? tok_found_i : found_q;

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
  end

  // prefix sums are nondecreasing, so setting bits high to low finds the last hit
  assign take = (CNT_W'(cand) < node_count_i) && (rd_data_i <= draw_i);

  assign rd_req_o    = addr_ph_q;
  assign rd_addr_o   = cand;
  assign tok_valid_o = cmp_ph_q;
  assign tok_found_o = take ? cand : found_q;

endmodule

`default_nettype wire

>>> hdl/weighted_index_sampler_top.sv
`default_nettype none

// Weighted index sampler (roulette-wheel selection over a prefix-sum table).
// Input channel in_valid_i/in_ready_o carries operation_i, weight_i, draw_i:
//   clear  - empties the table, no result.
//   append - stores the running total as the node's prefix sum and adds the
//            weight (saturating); ignored when MAX_NODES nodes are held.
//   sample - returns the last node whose prefix sum is at most draw_i, or
//            out_of_range_o=1 with node_index_o=0 if the table is empty or
//            draw_i is not below the total. Code 3 is dropped.
// Output channel out_valid_o/out_ready_i carries node_index_o, out_of_range_o.
// Clear and append complete without leaving idle. An in-range sample runs a
// search through a chain of clog2(MAX_NODES)
// cells; each resolves one index bit with a read of the single table port and
// a compare; no input is taken until it ends. An out-of-range sample skips it.
// A result sits in the output register; the next transaction is taken while
// it waits. If a new result is ready while the old one is stalled, the block
// holds it and takes no input until the output register frees up.
// Reset empties the table (count and total to zero); table contents are not
// cleared and need no sweep, since entries at or above the count are never used.
module weighted_index_sampler_top import wis_pkg::*; #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OP_W-1:0]     operation_i,
  input  wire logic [WEIGHT_W-1:0] weight_i,
  input  wire logic [DRAW_W-1:0]   draw_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [NODE_W-1:0]   node_index_o,
  output logic                     out_of_range_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned W_EFF = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q;
  total_t            total_q;
  total_t            draw_q;
  logic [IDX_W-1:0]  res_found_q;
  logic              res_oor_q;

  logic              out_valid_q;
  logic [NODE_W-1:0] node_index_q;
  logic              oor_q;

  logic              in_acc;
  op_e               op;
  logic              full;
  logic              sample_oor;
  logic [TOTAL_W:0]  sum;
  total_t            total_sat;

  // FSM outputs
  logic              start;
  logic              do_append;
  logic              capture;
  logic              load_out;

  // cell chain
  logic              tok_v [IDX_W+1];
  logic [IDX_W-1:0]  tok_f [IDX_W+1];
  logic [IDX_W-1:0]  req_vec;
  logic [IDX_W-1:0]  cell_addr [IDX_W];
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  mem_addr;
  total_t            rd_data;

  assign op         = op_e'(operation_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (count_q >= CNT_W'(MAX_NODES));
  assign sample_oor = (count_q == '0) || (total_t'(draw_i) >= total_q);

  assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(weight_i[W_EFF-1:0]);
  assign total_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op == OP_SAMPLE)) begin
          state_d = sample_oor ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_v[IDX_W]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    start      = 1'b0;
    do_append  = 1'b0;
    capture    = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        start      = in_acc && (op == OP_SAMPLE) && !sample_oor;
        do_append  = in_acc && (op == OP_APPEND) && !full;
      end
      ST_SEARCH: capture  = tok_v[IDX_W];
      ST_DONE:   load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && (op == OP_CLEAR)) begin
        count_q <= '0;
        total_q <= '0;
      end else if (do_append) begin
        count_q <= count_q + CNT_W'(1);
        total_q <= total_sat;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (op == OP_SAMPLE)) begin
      draw_q      <= total_t'(draw_i);
      res_oor_q   <= sample_oor;
      res_found_q <= '0;
    end else if (capture) begin
      res_found_q <= tok_f[IDX_W];
    end
    if (load_out) begin
      node_index_q <= res_oor_q ? '0 : NODE_W'(res_found_q);
      oor_q        <= res_oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign node_index_o   = node_index_q;
  assign out_of_range_o = oor_q;

  // cell chain, most significant index bit first
  assign tok_v[0] = start;
  assign tok_f[0] = '0;

  for (genvar i = 0; i < IDX_W; i++) begin : g_cell
    wis_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .BIT   (IDX_W - 1 - i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tok_valid_i  (tok_v[i]),
      .tok_found_i  (tok_f[i]),
      .node_count_i (count_q),
      .draw_i       (draw_q),
      .rd_data_i    (rd_data),
      .rd_req_o     (req_vec[i]),
      .rd_addr_o    (cell_addr[i]),
      .tok_valid_o  (tok_v[i+1]),
      .tok_found_o  (tok_f[i+1])
    );
  end

  // only one cell drives the read port at a time
  always_comb begin
    rd_addr = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (req_vec[i]) begin
        rd_addr = rd_addr | cell_addr[i];
      end
    end
  end

  // appends only happen in idle, searches only outside it
  assign mem_addr = (state_q == ST_IDLE) ? count_q[IDX_W-1:0] : rd_addr;

  wis_table #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (IDX_W),
    .DATA_W (TOTAL_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_append),
    .addr_i  (mem_addr),
    .wdata_i (total_q),
    .rdata_o (rd_data)
  );

`ifndef SYNTHESIS
  a_one_reader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(req_vec))
    else $error("more than one cell on the table read port");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_NODES))
    else $error("node count past capacity");

  a_tok_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_v[IDX_W] |-> (state_q == ST_SEARCH))
    else $error("search result outside search state");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (node_index_o == '0))
    else $error("out-of-range result with nonzero index");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && (state_q == ST_DONE)) |=> (state_q == ST_DONE))
    else $error("pending result dropped while output stalled");
`endif

endmodule

`default_nettype wire
